/* design/multichannel_moving_average_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel moving average
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define MMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg
// Widths, derived sizes, queue item and back-end state type.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int CHANNELS = 8;
  localparam int WINDOW   = 16;

  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 3;
  localparam int FILL_W   = 5;

  // channel field only reaches 2**CHAN_W channels
  localparam int CH_USED  = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
  localparam int CH_IDX_W = (CH_USED > 1) ? $clog2(CH_USED) : 1;
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int TOTAL_W  = SAMPLE_W + CNT_W;
  localparam int DEPTH    = CH_USED * WINDOW;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // divider: DIV_RADIX quotient bits per cycle
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = (TOTAL_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_W     = DIV_STEPS * DIV_RADIX;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       in_range;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPDATE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

/* design/mma_if.sv */
// ----------------------------------------------------------------------------
// mma_in_if / mma_out_if
// Valid/ready stream channels for sample beats and average beats.
// ----------------------------------------------------------------------------
interface mma_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mma_pkg::SAMPLE_W-1:0]  sample;
  logic [mma_pkg::CHAN_W-1:0]           channel;

  modport source(output valid, sample, channel, input ready);
  modport sink(input valid, sample, channel, output ready);
endinterface

interface mma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mma_pkg::SAMPLE_W-1:0]  average;
  logic [mma_pkg::CHAN_W-1:0]           channel_out;
  logic [mma_pkg::FILL_W-1:0]           fill_count;

  modport source(output valid, average, channel_out, fill_count, input ready);
  modport sink(input valid, average, channel_out, fill_count, output ready);
endinterface

/* design/mma_front.sv */
// ----------------------------------------------------------------------------
// mma_front
// Takes sample beats and tags each with its channel range check.
// ----------------------------------------------------------------------------
module mma_front (
  mma_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output mma_pkg::item_t  push_item
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_item.sample   = in_ch.sample;
    push_item.channel  = in_ch.channel;
    push_item.in_range = int'(in_ch.channel) < mma_pkg::CHANNELS;
  end

endmodule

/* design/mma_fifo.sv */
// ----------------------------------------------------------------------------
// mma_fifo
// Short item queue between front and back.
// ----------------------------------------------------------------------------
module mma_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mma_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output mma_pkg::item_t  head,
  output logic            head_valid
);

  mma_pkg::item_t                  ent_r [mma_pkg::QUEUE_DEPTH];
  logic [mma_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mma_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mma_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full       = count_r == mma_pkg::QCNT_W'(mma_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mma_pkg::QPTR_W'(mma_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mma_pkg::QPTR_W'(mma_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/mma_div.sv */
// ----------------------------------------------------------------------------
// mma_div
// Iterative signed-by-unsigned divider, truncating toward zero.
// ----------------------------------------------------------------------------
module mma_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [mma_pkg::TOTAL_W-1:0]   dividend,
  input  logic [mma_pkg::CNT_W-1:0]            divisor,
  output logic                                 done,
  output logic signed [mma_pkg::SAMPLE_W-1:0]  quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [mma_pkg::DIV_CNT_W-1:0]     step_r;
  logic                              neg_r;
  logic [mma_pkg::DIV_W-1:0]         q_r, q_nxt;
  logic [mma_pkg::CNT_W:0]           rem_r, rem_nxt;
  logic [mma_pkg::CNT_W-1:0]         d_r;
  logic [mma_pkg::TOTAL_W-1:0]       mag;
  logic [mma_pkg::SAMPLE_W-1:0]      q_low;

  assign mag = dividend[mma_pkg::TOTAL_W-1] ? mma_pkg::TOTAL_W'(-dividend)
                                            : mma_pkg::TOTAL_W'(dividend);

  // restoring steps, DIV_RADIX bits per cycle
  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < mma_pkg::DIV_RADIX; k++) begin
      rem_nxt = {rem_nxt[mma_pkg::CNT_W-1:0], q_nxt[mma_pkg::DIV_W-1]};
      q_nxt   = {q_nxt[mma_pkg::DIV_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, d_r}) begin
        rem_nxt  = rem_nxt - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end
    end
  end

  assign q_low    = q_r[mma_pkg::SAMPLE_W-1:0];
  assign quotient = neg_r ? $signed(-q_low) : $signed(q_low);
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == mma_pkg::DIV_CNT_W'(mma_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mma_pkg::DIV_W'(mag);
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[mma_pkg::TOTAL_W-1];
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

/* design/mma_back.sv */
// ----------------------------------------------------------------------------
// mma_back
// Per-channel window update, average divide and output register.
// ----------------------------------------------------------------------------
module mma_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mma_pkg::item_t  head,
  input  logic            head_valid,
  output logic            pop,
  mma_out_if.source       out_ch
);

  mma_pkg::back_state_t state_r, state_nxt;

  // sample store with per-entry valid bits; invalid reads as zero
  logic signed [mma_pkg::SAMPLE_W-1:0] mem [mma_pkg::DEPTH];
  logic [mma_pkg::DEPTH-1:0]           vld_r;

  logic signed [mma_pkg::TOTAL_W-1:0]  total_r [mma_pkg::CH_USED];
  logic [mma_pkg::POS_W-1:0]           wpos_r  [mma_pkg::CH_USED];
  logic [mma_pkg::CNT_W-1:0]           cnt_r   [mma_pkg::CH_USED];

  mma_pkg::item_t                      cur_r;
  logic [mma_pkg::POS_W-1:0]           cur_pos_r;
  logic [mma_pkg::ADDR_W-1:0]          cur_addr_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                                rd_vld_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] res_avg_r;
  logic [mma_pkg::FILL_W-1:0]          res_fill_r;

  logic                                out_valid_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] out_avg_r;
  logic [mma_pkg::CHAN_W-1:0]          out_chan_r;
  logic [mma_pkg::FILL_W-1:0]          out_fill_r;

  logic                                wr_en, div_start, load_out;
  logic [mma_pkg::CH_IDX_W-1:0]        head_idx, cur_idx;
  logic [mma_pkg::POS_W-1:0]           head_pos, new_pos;
  logic [mma_pkg::ADDR_W-1:0]          head_addr;
  logic signed [mma_pkg::SAMPLE_W-1:0] old_sample;
  logic signed [mma_pkg::TOTAL_W-1:0]  new_total;
  logic [mma_pkg::CNT_W-1:0]           new_cnt;
  logic                                div_done;
  logic signed [mma_pkg::SAMPLE_W-1:0] div_quot;

  assign head_idx  = head.channel[mma_pkg::CH_IDX_W-1:0];
  assign head_pos  = wpos_r[head_idx];
  assign head_addr = mma_pkg::ADDR_W'(int'(head_idx) * mma_pkg::WINDOW + int'(head_pos));

  assign cur_idx    = cur_r.channel[mma_pkg::CH_IDX_W-1:0];
  assign old_sample = rd_vld_r ? rd_data_r : '0;
  assign new_total  = total_r[cur_idx] - mma_pkg::TOTAL_W'(old_sample)
                      + mma_pkg::TOTAL_W'($signed(cur_r.sample));
  assign new_cnt    = (int'(cnt_r[cur_idx]) < mma_pkg::WINDOW) ? cnt_r[cur_idx] + 1'b1
                                                              : cnt_r[cur_idx];
  assign new_pos    = (cur_pos_r == mma_pkg::POS_W'(mma_pkg::WINDOW - 1)) ? '0
                                                                         : cur_pos_r + 1'b1;

  mma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (new_total),
    .divisor  (new_cnt),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mma_pkg::B_IDLE: begin
        if (head_valid) begin
          state_nxt = head.in_range ? mma_pkg::B_UPDATE : mma_pkg::B_DONE;
        end
      end
      mma_pkg::B_UPDATE: state_nxt = mma_pkg::B_DIV;
      mma_pkg::B_DIV: begin
        if (div_done) begin
          state_nxt = mma_pkg::B_DONE;
        end
      end
      mma_pkg::B_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = mma_pkg::B_IDLE;
        end
      end
      default: state_nxt = mma_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      mma_pkg::B_IDLE: pop = head_valid;
      mma_pkg::B_UPDATE: begin
        wr_en     = 1'b1;
        div_start = 1'b1;
      end
      mma_pkg::B_DIV: ;
      mma_pkg::B_DONE: load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mma_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      for (int c = 0; c < mma_pkg::CH_USED; c++) begin
        total_r[c] <= '0;
        wpos_r[c]  <= '0;
        cnt_r[c]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[cur_addr_r] <= 1'b1;
        total_r[cur_idx]  <= new_total;
        wpos_r[cur_idx]   <= new_pos;
        cnt_r[cur_idx]    <= new_cnt;
      end
    end
  end

  // sample store port: registered read at pop, write at update
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[head_addr];
    end
    if (wr_en) begin
      mem[cur_addr_r] <= cur_r.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head;
      cur_pos_r  <= head_pos;
      cur_addr_r <= head_addr;
      rd_vld_r   <= vld_r[head_addr];
      if (!head.in_range) begin
        res_avg_r  <= '0;
        res_fill_r <= '0;
      end
    end
    if (wr_en) begin
      res_fill_r <= mma_pkg::FILL_W'(new_cnt);
    end
    if (div_done) begin
      res_avg_r <= div_quot;
    end
    if (load_out) begin
      out_avg_r  <= res_avg_r;
      out_chan_r <= cur_r.channel;
      out_fill_r <= res_fill_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.average     = out_avg_r;
  assign out_ch.channel_out = out_chan_r;
  assign out_ch.fill_count  = out_fill_r;

endmodule

/* design/multichannel_moving_average.sv */
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel moving average over the last WINDOW samples, Q11.4 in and out.
// ----------------------------------------------------------------------------
//
//   beat      dir  fields                                 handshake
//   --------  ---  -------------------------------------  -----------
//   in_ch     in   sample[15:0] s, channel[2:0]           valid/ready
//   out_ch    out  average[15:0] s, channel_out[2:0],     valid/ready
//                  fill_count[4:0]
//
// An in-range beat goes from queue head to output register through a store read,
// the update, DIV_STEPS (6) steps of the 4-bit-a-cycle divider plus its done
// strobe, and a hand-off that waits on out_ch; out-of-range beats skip update and divide.
// Reset clears the sample store at once through per-entry valid bits; there
// is no clearing pass and the first beat is taken right after reset.
// A 2-deep queue lets in_ch take up to two beats while the back end divides or out_ch
// stalls; the output register holds a beat while the next one is worked on.
module multichannel_moving_average (
  input  logic       clk,
  input  logic       rst_n,
  mma_in_if.sink     in_ch,
  mma_out_if.source  out_ch
);

`include "multichannel_moving_average_macros.svh"

  // front -> queue
  logic            push;
  mma_pkg::item_t  push_item;
  logic            q_full;

  // queue -> back
  mma_pkg::item_t  head;
  logic            head_valid;
  logic            pop;

  // front: range check on channel, ready follows queue space
  mma_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  mma_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // back: read-modify-write of the channel's window, then divide
  mma_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // out-of-range channel results are all zero
  `MMA_ASSERT_NOW(a_oor_zero, out_ch.valid && (int'(out_ch.channel_out) >= mma_pkg::CHANNELS), (out_ch.average == '0) && (out_ch.fill_count == '0), "out-of-range beat has nonzero result")

  // back only pops a queued item
  `MMA_ASSERT_NOW(a_pop_nonempty, pop, head_valid, "pop from empty queue")

  // one item at a time in the back end
  `MMA_ASSERT_NEXT(a_pop_spacing, pop, !pop, "back popped on consecutive cycles")

endmodule
